@@ rtl/core/earliest_free_server_dispatcher_core_assert.svh @@
// assertion macros for the earliest free server dispatcher
// used by earliest_free_server_dispatcher_core, no other dependencies
`ifndef EARLIEST_FREE_SERVER_DISPATCHER_CORE_ASSERT_SVH
`define EARLIEST_FREE_SERVER_DISPATCHER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define EFSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efsd assertion failed");

// next-cycle implication, disabled in reset
`define EFSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efsd assertion failed");

`else

`define EFSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define EFSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/efsd_pkg.sv @@
// shared widths, payload types and constants of the dispatcher
// no dependencies
`default_nettype none

package efsd_pkg;

  localparam int ARR_W  = 32;
  localparam int LEN_W  = 20;
  localparam int ID_W   = 20;
  localparam int IDX_W  = 4;
  localparam int END_W  = 48;
  localparam int CFG_W  = 5;

  localparam int DEF_MAX_SERVERS = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [END_W-1:0] END_MAX   = {END_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [LEN_W-1:0] job_length;
    logic [ID_W-1:0]  job_id;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] server_index;
    logic [ID_W-1:0]  assigned_job_id;
    logic [END_W-1:0] finish_time;
  } out_item_t;

  typedef struct packed {
    logic is_free;
    logic is_less;
  } scan_res_t;

endpackage

`default_nettype wire

@@ rtl/core/efsd_chan_if.sv @@
// valid/ready channel interfaces for job input, result output and config
// depends on efsd_pkg
`default_nettype none

interface efsd_in_if
  import efsd_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface efsd_out_if
  import efsd_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface efsd_cfg_if
  import efsd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/efsd_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module efsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/efsd_scan_unit.sv @@
// shared compare unit: one server end time against arrival and running minimum
// depends on efsd_pkg
`default_nettype none

module efsd_scan_unit
  import efsd_pkg::*;
(
  input  wire logic [END_W-1:0] elem_end,
  input  wire logic [ARR_W-1:0] arrival,
  input  wire logic [END_W-1:0] best_end,
  output      scan_res_t        res
);
  always_comb begin
    res.is_free = elem_end < END_W'(arrival);
    res.is_less = elem_end < best_end;
  end

endmodule

`default_nettype wire

@@ rtl/core/efsd_finish_unit.sv @@
// finish time adder with saturation at the end time maximum
// depends on efsd_pkg
`default_nettype none

module efsd_finish_unit
  import efsd_pkg::*;
(
  input  wire logic [END_W-1:0] base,
  input  wire logic [LEN_W-1:0] len,
  input  wire logic             sub_one,
  output      logic [END_W-1:0] finish
);
  logic [END_W:0] sum;

  always_comb begin
    // base is at least one whenever sub_one is set, so no wrap below zero
    sum    = {1'b0, base} + (END_W+1)'(len) - (END_W+1)'(sub_one);
    finish = sum[END_W] ? END_MAX : sum[END_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/earliest_free_server_dispatcher_core.sv @@
// top level of the earliest free server dispatcher: sequencer, end time ram,
// valid bits and result register; uses efsd_pkg, efsd_chan_if, efsd_ram,
// efsd_scan_unit, efsd_finish_unit and the assertion macro header
//
//  channel    dir  transfer when         payload
//  in_chan    in   valid && ready        arrival_time, job_length, job_id
//  out_chan   out  valid && ready        server_index, assigned_job_id, finish_time
//  cfg_chan   in   valid && ready        servers_in_use (always ready)
//
// a job passes from one input transfer to the next through these steps: the
// input is accepted, the end time ram is read once per server in use, the
// last returned end time is compared, and the update writes the result;
// the input is taken only in idle; a new job may be accepted while the result
// register still holds an untaken result, and the update cycle waits for it
// reset clears the valid bits at once, so every end time reads as zero with
// no clearing pass; servers_in_use resets to 16
`default_nettype none

`include "earliest_free_server_dispatcher_core_assert.svh"

module earliest_free_server_dispatcher_core
  import efsd_pkg::*;
#(
  parameter int MAX_SERVERS = DEF_MAX_SERVERS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  efsd_in_if.sink   in_chan,
  efsd_out_if.source out_chan,
  efsd_cfg_if.sink  cfg_chan
);
  // index and count widths
  localparam int IW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW   = $clog2(MAX_SERVERS + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;

  // latched job
  logic [ARR_W-1:0] arr_r;
  logic [LEN_W-1:0] len_r;
  logic [ID_W-1:0]  id_r;
  logic [CW-1:0]    cnt_r;

  // scan pointers: read issue and returning data tag
  logic [CW-1:0]    rd_idx_r;
  logic [IW-1:0]    tag_r;
  logic             pend_r;
  logic             last_r;

  // scan results
  logic             found_r;
  logic [IW-1:0]    free_idx_r;
  logic [IW-1:0]    best_idx_r;
  logic [END_W-1:0] best_end_r;

  logic [MAX_SERVERS-1:0] srv_vld_r;

  logic             out_vld_r;
  out_item_t        out_data_r;

  // ram
  logic             ram_we, ram_re;
  logic [END_W-1:0] ram_rdata;
  logic [IW-1:0]    pick;
  logic [END_W-1:0] finish;

  logic             in_xfer, out_xfer, out_free;
  logic [CMPW-1:0]  cfg_ext;
  logic [CW-1:0]    cnt_eff;
  logic [END_W-1:0] elem_end;
  scan_res_t        scan_res;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_data_r;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_vld_r && out_chan.ready;
  assign out_free = !out_vld_r || out_chan.ready;

  // effective server count: zero acts as one, clamp at the bank size
  always_comb begin
    cfg_ext = CMPW'(cfg_r);
    if (cfg_ext == '0) begin
      cnt_eff = CW'(1);
    end else if (cfg_ext > CMPW'(MAX_SERVERS)) begin
      cnt_eff = CW'(MAX_SERVERS);
    end else begin
      cnt_eff = CW'(cfg_ext);
    end
  end

  // ram traffic: one read per scan cycle until all servers in use are read, one write in the update cycle
  assign ram_re = (state_r == ST_SCAN) && (rd_idx_r != cnt_r);
  assign ram_we = (state_r == ST_FIN) && out_free;
  assign pick   = found_r ? free_idx_r : best_idx_r;

  efsd_ram #(
    .WIDTH (END_W),
    .DEPTH (MAX_SERVERS)
  ) u_end_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata (finish),
    .re    (ram_re),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // a never written server reads as zero end time
  assign elem_end = srv_vld_r[tag_r] ? ram_rdata : '0;

  efsd_scan_unit u_scan (
    .elem_end (elem_end),
    .arrival  (arr_r),
    .best_end (best_end_r),
    .res      (scan_res)
  );

  // free server: arrival + length - 1, else earliest end + length
  efsd_finish_unit u_finish (
    .base    (found_r ? END_W'(arr_r) : best_end_r),
    .len     (len_r),
    .sub_one (found_r),
    .finish  (finish)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r && last_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_r     <= CFG_RESET;
      srv_vld_r <= '0;
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        cfg_r <= cfg_chan.data;
      end
      pend_r <= ram_re;
      if (in_xfer) begin
        found_r <= 1'b0;
      end else if (pend_r && !found_r && scan_res.is_free) begin
        found_r <= 1'b1;
      end
      if (ram_we) begin
        srv_vld_r[pick] <= 1'b1;
        out_vld_r       <= 1'b1;
      end else if (out_xfer) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      arr_r    <= in_chan.data.arrival_time;
      len_r    <= in_chan.data.job_length;
      id_r     <= in_chan.data.job_id;
      cnt_r    <= cnt_eff;
      rd_idx_r <= '0;
    end else if (ram_re) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (ram_re) begin
      tag_r  <= rd_idx_r[IW-1:0];
      last_r <= (rd_idx_r == cnt_r - CW'(1));
    end
    if (pend_r) begin
      // lowest free index wins, first hit only
      if (!found_r && scan_res.is_free) begin
        free_idx_r <= tag_r;
      end
      // strict less keeps the lowest index on ties
      if (tag_r == '0 || scan_res.is_less) begin
        best_end_r <= elem_end;
        best_idx_r <= tag_r;
      end
    end
    if (ram_we) begin
      out_data_r.server_index    <= IDX_W'(pick);
      out_data_r.assigned_job_id <= id_r;
      out_data_r.finish_time     <= finish;
    end
  end

  // checks on the sequencer
  `EFSD_ASSERT_SAME(a_rd_in_range, clk, rst_n, state_r == ST_SCAN, rd_idx_r <= cnt_r)
  `EFSD_ASSERT_SAME(a_wr_in_range, clk, rst_n, ram_we, CW'(pick) < cnt_r)
  `EFSD_ASSERT_SAME(a_pend_in_scan, clk, rst_n, pend_r, state_r == ST_SCAN)
  `EFSD_ASSERT_NEXT(a_wr_gives_result, clk, rst_n, ram_we, out_vld_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for earliest_free_server_dispatcher_core: directed jobs, then
// random job phases under several server counts and idling patterns
// depends on efsd_pkg, efsd_chan_if and the dispatcher rtl
`default_nettype none

module testbench;
  import efsd_pkg::*;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int IDLE_LIMIT = 3000;
  // wait after the last expected result so that a stray extra result is still checked
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 8;
  localparam int JOBS_PER_PHASE = 50;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // server counts per random phase: reset value, both extremes, out of range ones
  localparam int PHASE_SERVERS [NUM_PHASES] = '{16, 1, 0, 31, 5, 17, 2, 9};

  // tracks server end times, predicts each dispatch and checks results in order
  class dispatch_scoreboard;
    bit [END_W-1:0] end_time [DEF_MAX_SERVERS];
    bit [CFG_W-1:0] servers_in_use;
    out_item_t      due_results [$];
    int unsigned    errors;

    function new();
      foreach (end_time[i]) end_time[i] = '0;
      servers_in_use = CFG_RESET;
      errors = 0;
    endfunction

    function void set_server_count(bit [CFG_W-1:0] value);
      servers_in_use = value;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void note_job(in_item_t job);
      int unsigned    n;
      int unsigned    pick;
      int unsigned    i;
      bit             found;
      bit [END_W:0]   sum;
      out_item_t      res;
      // zero acts as one server, anything above the bank acts as the whole bank
      if (servers_in_use == 0) n = 1;
      else if (servers_in_use > DEF_MAX_SERVERS) n = DEF_MAX_SERVERS;
      else n = servers_in_use;
      found = 1'b0;
      pick = 0;
      for (i = 0; i < n && !found; i++) begin
        if (end_time[i] < job.arrival_time) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (found) begin
        sum = job.arrival_time + job.job_length - 1;
      end else begin
        for (i = 1; i < n; i++) begin
          if (end_time[i] < end_time[pick]) pick = i;
        end
        sum = end_time[pick] + job.job_length;
      end
      res.finish_time = (sum > END_MAX) ? END_MAX : sum[END_W-1:0];
      res.server_index = IDX_W'(pick);
      res.assigned_job_id = job.job_id;
      end_time[pick] = res.finish_time;
      due_results = {due_results, res};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with no job outstanding: server_index %0d assigned_job_id %0d",
               got.server_index, got.assigned_job_id);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.server_index !== want.server_index) begin
        $error("server_index mismatch: expected %0d, actual %0d",
               want.server_index, got.server_index);
        errors++;
      end
      if (got.assigned_job_id !== want.assigned_job_id) begin
        $error("assigned_job_id mismatch: expected %0d, actual %0d",
               want.assigned_job_id, got.assigned_job_id);
        errors++;
      end
      if (got.finish_time !== want.finish_time) begin
        $error("finish_time mismatch: expected %0d, actual %0d",
               want.finish_time, got.finish_time);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  efsd_in_if  in_if ();
  efsd_out_if out_if ();
  efsd_cfg_if cfg_if ();

  earliest_free_server_dispatcher_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  dispatch_scoreboard tracker;

  // percent of cycles in which the job source holds back or the result sink stalls
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // running arrival time of well-formed job streams
  bit [ARR_W-1:0] arrival_cursor;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result sink: ready redrawn every falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) tracker.check_result(out_if.data);
  end

  // hang detector: ends the run when no channel moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("earliest_free_server_dispatcher_core verification failed");
    $finish;
  end

  function automatic in_item_t job_of(bit [ARR_W-1:0] arrival, bit [LEN_W-1:0] length,
                                      bit [ID_W-1:0] id);
    in_item_t job;
    job.arrival_time = arrival;
    job.job_length = length;
    job.job_id = id;
    return job;
  endfunction

  function automatic void set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 36 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 36 : 0;
  endfunction

  // mostly an ordered arrival stream with bursts of equal and close arrivals, so that
  // the bank fills up and drains; one job in ten is out of order or degenerate
  function automatic in_item_t random_job();
    in_item_t    job;
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll <= 5) job.job_length = LEN_W'($urandom_range(64, 1));
    else if (roll <= 8) job.job_length = LEN_W'($urandom_range(1024, 65));
    else job.job_length = LEN_W'($urandom_range(20000, 1025));
    job.job_id = ID_W'($urandom);
    if ($urandom_range(99) < 90) begin
      roll = $urandom_range(9);
      if (roll <= 1) arrival_cursor = arrival_cursor;
      else if (roll <= 6) arrival_cursor = arrival_cursor + $urandom_range(4, 1);
      else if (roll <= 8) arrival_cursor = arrival_cursor + $urandom_range(40, 5);
      else arrival_cursor = arrival_cursor + $urandom_range(2000, 41);
      job.arrival_time = arrival_cursor;
    end else begin
      case ($urandom_range(3))
        0: job.arrival_time = '0;
        1: begin
          job.arrival_time = arrival_cursor;
          job.job_length = '0;
        end
        2: job.arrival_time = $urandom_range(arrival_cursor);
        default: job.arrival_time = arrival_cursor + $urandom_range(100000);
      endcase
    end
    return job;
  endfunction

  // offers one job after a random hold-off and waits for its transfer
  task automatic send_job(in_item_t job);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = job;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.note_job(job);
  endtask

  task automatic stop_jobs();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // server count changes only once every dispatched job has reported back
  task automatic write_server_count(bit [CFG_W-1:0] value);
    stop_jobs();
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.set_server_count(value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int p;
    int k;
    tracker = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    arrival_cursor = 100;
    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed jobs at the reset server count
    send_job(job_of(0, 5, 0));                   // zero arrival: nothing free, earliest wins
    send_job(job_of(1, 0, 20'hFFFFF));           // zero length on a free server
    send_job(job_of(1, 50, 1));
    send_job(job_of(2, 1, 2));
    send_job(job_of(2, 1, 3));                   // equal arrivals keep feed order

    // two servers so the bank is easy to fill
    write_server_count(CFG_W'(2));
    send_job(job_of(3, 10, 4));                  // both busy, earliest end extends
    send_job(job_of(3, 0, 5));                   // busy with zero length
    send_job(job_of(20, 0, 6));                  // free again, zero length
    send_job(job_of(10, 7, 7));                  // arrival goes backwards
    send_job(job_of(32'hFFFFFFFF, 20'hFFFFF, 8)); // top arrival and length

    // random phases, each with its own server count and idling pattern
    for (p = 0; p < NUM_PHASES; p++) begin
      write_server_count(CFG_W'(PHASE_SERVERS[p]));
      set_idling(idle_mode_t'(p % 4));
      for (k = 0; k < JOBS_PER_PHASE; k++) send_job(random_job());
    end

    stop_jobs();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("earliest_free_server_dispatcher_core verification clean");
    end else begin
      $display("earliest_free_server_dispatcher_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/efsd_pkg.sv
rtl/core/efsd_chan_if.sv
rtl/core/efsd_ram.sv
rtl/core/efsd_scan_unit.sv
rtl/core/efsd_finish_unit.sv
rtl/core/earliest_free_server_dispatcher_core.sv
bench/testbench.sv
